[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the stereo gain block; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define SGMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent must hold in the cycle after the antecedent
`define SGMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SGMS_ASSERT_NOW(lbl, ante, cons, msg)
`define SGMS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/sgms_pkg.sv]
// ----------------------------------------------------------------------------
// sgms_pkg
// Constants, register indexes and sequencer states of the stereo gain block.
// ----------------------------------------------------------------------------
package sgms_pkg;

    localparam int SAMPLE_BITS_DEF = 24;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 25;

    localparam logic [CFG_IW-1:0] REG_IN_TRIM  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_MAIN     = 3'd1;
    localparam logic [CFG_IW-1:0] REG_OUT_TRIM = 3'd2;
    localparam logic [CFG_IW-1:0] REG_WIDTH    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_CEILING  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_COEF     = 3'd5;
    localparam logic [CFG_IW-1:0] REG_MODE     = 3'd6;

    // register reset values
    localparam int RST_IN_TRIM  = 4174470;
    localparam int RST_MAIN     = 2035176;
    localparam int RST_OUT_TRIM = 4174470;
    localparam int RST_WIDTH    = 32768;
    localparam int RST_CEILING  = 64553;
    localparam int RST_COEF     = 69614;
    localparam int RST_MODE     = 2;

    // smoother and limits
    localparam int GAIN_ONE     = 1048576;
    localparam int CEIL_RESET   = 62259;
    localparam int WIDTH_MAX    = 65536;
    localparam int CEIL_MIN     = 45875;
    localparam int CEIL_MAX     = 65536;
    localparam int COEF_MAX     = 16777216;
    localparam int PEAK_RELEASE = 2013;
    localparam int TANH_LIMIT   = 8 << 20;
    localparam int TANH_27      = 27 << 20;

    // mode flag bits
    localparam int MODE_BYPASS   = 0;
    localparam int MODE_LINK     = 1;
    localparam int MODE_INV_L    = 2;
    localparam int MODE_INV_R    = 3;
    localparam int MODE_MONO_IN  = 4;
    localparam int MODE_MONO_OUT = 5;

    // shared unit widths: multiplier operand, divider dividend and divisor
    localparam int MUL_BW = 25;
    localparam int DIV_DW = 52;
    localparam int DIV_VW = 30;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SMOOTH = 14'b00000000000010,
        S_POL    = 14'b00000000000100,
        S_TRIM   = 14'b00000000001000,
        S_MS     = 14'b00000000010000,
        S_MAIN   = 14'b00000000100000,
        S_OUTG   = 14'b00000001000000,
        S_CDIV   = 14'b00000010000000,
        S_CU2    = 14'b00000100000000,
        S_CNUM   = 14'b00001000000000,
        S_CTDIV  = 14'b00010000000000,
        S_CY     = 14'b00100000000000,
        S_PEAK   = 14'b01000000000000,
        S_OUTP   = 14'b10000000000000
    } t_state;

endpackage

[rtl/stereo_gain_ms_soft_ceiling_top.sv]
// ----------------------------------------------------------------------------
// stereo_gain_ms_soft_ceiling_top
// Stereo gain stage with mid/side width, soft ceiling and peak meters.
// ----------------------------------------------------------------------------
// One stereo frame is taken per item and processed by a small sequencer around
// one shared bit-serial multiplier (one multiplier bit per cycle, stopping as
// soon as the remaining bits are zero) and one restoring divider (one quotient
// bit per cycle over a 52-bit dividend). A frame runs 5 smoother updates,
// input trim, mid/side, main gain, output trim, then per channel two divisions
// and four multiplications for the ceiling and meter. The time per item is
// set mostly by the two divisions per channel and the bit lengths of the
// gains and of the smoothing coefficient. In bypass only the smoothers run,
// for a time that depends on the smoothing coefficient. The input stalls
// while a frame is in flight; a finished item waits in the output register
// while the next frame is taken.
// Configuration writes take effect immediately and must be made while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_gain_ms_soft_ceiling_top #(
    parameter int SAMPLE_BITS = sgms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]     i_right_sample,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]     o_left_out,
    output logic signed [SAMPLE_BITS-1:0]     o_right_out,
    output logic        [SAMPLE_BITS-2:0]     o_peak_left,
    output logic        [SAMPLE_BITS-2:0]     o_peak_right,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [sgms_pkg::CFG_IW-1:0]       i_cfg_index,
    input  logic [sgms_pkg::CFG_DW-1:0]       i_cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int BW  = sgms_pkg::MUL_BW;
    localparam int AW  = (SB + 8 > 30) ? SB + 8 : 30;
    localparam int PW  = AW + BW;
    localparam int XW  = SB + 12;
    localparam int DW  = sgms_pkg::DIV_DW;
    localparam int VW  = sgms_pkg::DIV_VW;
    localparam int DCW = $clog2(DW + 1);
    localparam int SHU = 37 - SB;

    localparam logic signed [PW-1:0] K19    = PW'(1) << 19;
    localparam logic signed [PW-1:0] K16    = PW'(1) << 16;
    localparam logic signed [PW-1:0] K23    = PW'(1) << 23;
    localparam logic signed [PW-1:0] KSH    = PW'(1) << (SHU - 1);
    localparam logic signed [PW-1:0] LIM_P  = PW'(1) << (SB + 6);
    localparam logic signed [PW-1:0] LIM_N  = -LIM_P;
    localparam logic signed [PW-1:0] SMAX_P = (PW'(1) << (SB - 1)) - PW'(1);
    localparam logic signed [PW-1:0] SMIN_P = -SMAX_P - PW'(1);
    localparam logic signed [SB-1:0] SMIN_S = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] SMAX_S = {1'b0, {(SB-1){1'b1}}};
    localparam logic [DW-1:0]        U_LIM  = DW'(sgms_pkg::TANH_LIMIT);

    // saturating negate of one sample
    function automatic logic signed [SB-1:0] neg_sat(input logic signed [SB-1:0] v);
        return (v == SMIN_S) ? SMAX_S : -v;
    endfunction

    // configuration registers
    logic [23:0] r_cfg_in, r_cfg_main, r_cfg_out;
    logic [16:0] r_cfg_width, r_cfg_ceil;
    logic [24:0] r_cfg_coef;
    logic [5:0]  r_cfg_mode;

    // smoothers and meters
    logic [23:0] r_s_in, n_s_in, r_s_main, n_s_main, r_s_out, n_s_out;
    logic [16:0] r_s_width, n_s_width, r_s_ceil, n_s_ceil;
    logic [SB-2:0] r_pkl, n_pkl, r_pkr, n_pkr;

    // sequencer
    sgms_pkg::t_state r_state, n_state;
    logic        r_pend, n_pend;
    logic        r_ch, n_ch;
    logic [2:0]  r_k, n_k;

    // frame working registers
    logic signed [SB-1:0] r_inl, n_inl, r_inr, n_inr;
    logic signed [SB-1:0] r_yl, n_yl, r_yr, n_yr;
    logic signed [XW-1:0] r_xl, n_xl, r_xr, n_xr;
    logic [23:0] r_umag, n_umag;
    logic        r_uneg, n_uneg;
    logic [26:0] r_u2, n_u2;
    logic [DW-1:0] r_num, n_num;
    logic [23:0] r_tmag, n_tmag;

    // output register
    logic                 r_ovalid, n_ovalid;
    logic signed [SB-1:0] r_ol, n_ol, r_or, n_or;
    logic [SB-2:0]        r_opl, n_opl, r_opr, n_opr;

    // shared multiplier
    logic signed [PW-1:0] r_macc, r_mcd;
    logic [BW-1:0]        r_mplr;
    logic                 m_go;
    logic signed [AW-1:0] m_a;
    logic [BW-1:0]        m_b;

    // shared divider
    logic [DW-1:0]  r_dq;
    logic [VW-1:0]  r_drem, r_dvs;
    logic [DCW-1:0] r_dcnt;
    logic           d_go;
    logic [DW-1:0]  d_dvd;
    logic [VW-1:0]  d_dvs;
    logic [VW:0]    d_trial;
    logic           d_fit;

    logic u_done;

    // effective targets
    logic [24:0] coef_e;
    logic [16:0] width_e, ceil_e;
    logic inv_l, inv_r;

    assign coef_e  = (r_cfg_coef > 25'(sgms_pkg::COEF_MAX)) ? 25'(sgms_pkg::COEF_MAX)
                                                            : r_cfg_coef;
    assign width_e = (r_cfg_width > 17'(sgms_pkg::WIDTH_MAX)) ? 17'(sgms_pkg::WIDTH_MAX)
                                                              : r_cfg_width;
    assign ceil_e  = (r_cfg_ceil < 17'(sgms_pkg::CEIL_MIN)) ? 17'(sgms_pkg::CEIL_MIN) :
                     (r_cfg_ceil > 17'(sgms_pkg::CEIL_MAX)) ? 17'(sgms_pkg::CEIL_MAX) :
                     r_cfg_ceil;
    assign inv_l   = r_cfg_mode[sgms_pkg::MODE_INV_L];
    assign inv_r   = r_cfg_mode[sgms_pkg::MODE_LINK] ? inv_l
                                                     : r_cfg_mode[sgms_pkg::MODE_INV_R];

    assign u_done  = r_pend && (r_mplr == '0) && (r_dcnt == '0);

    // smoother selection by index
    logic [24:0] sm_tgt, sm_cur;
    logic signed [25:0] sm_d;
    logic signed [PW-1:0] sm_new;

    always_comb begin
        case (r_k)
            3'd0: begin sm_tgt = {1'b0, r_cfg_in};     sm_cur = {1'b0, r_s_in};     end
            3'd1: begin sm_tgt = {1'b0, r_cfg_main};   sm_cur = {1'b0, r_s_main};   end
            3'd2: begin sm_tgt = {1'b0, r_cfg_out};    sm_cur = {1'b0, r_s_out};    end
            3'd3: begin sm_tgt = {8'd0, width_e};      sm_cur = {8'd0, r_s_width};  end
            default: begin sm_tgt = {8'd0, ceil_e};    sm_cur = {8'd0, r_s_ceil};   end
        endcase
    end

    assign sm_d   = $signed({1'b0, sm_tgt}) - $signed({1'b0, sm_cur});
    assign sm_new = PW'($signed({1'b0, sm_cur})) + ((r_macc + K23) >>> 24);

    // product post-processing
    logic signed [PW-1:0] p_r20, p_main, p_rsh, p_y, ms_sum, ms_side;
    assign p_r20   = (r_macc + K19) >>> 20;
    assign p_main  = (p_r20 > LIM_P) ? LIM_P : ((p_r20 < LIM_N) ? LIM_N : p_r20);
    assign p_rsh   = (r_macc + KSH) >>> SHU;
    assign p_y     = (p_rsh > SMAX_P) ? SMAX_P : ((p_rsh < SMIN_P) ? SMIN_P : p_rsh);
    assign ms_sum  = (PW'(r_xl) + PW'(r_xr)) <<< 16;
    assign ms_side = r_macc <<< 1;

    // channel selection
    logic signed [XW-1:0] x_sel;
    logic [XW-1:0] x_mag;
    logic signed [SB-1:0] y_sel, y_abs, pl, pr;
    logic [SB-2:0] pk_a, pk_cur, pk_new;
    logic signed [SB:0] pk_d;
    logic signed [24:0] t_s;
    logic [DW-1:0] q_clamp;

    assign x_sel  = r_ch ? r_xr : r_xl;
    assign x_mag  = x_sel[XW-1] ? XW'(-x_sel) : XW'(x_sel);
    assign y_sel  = r_ch ? r_yr : r_yl;
    assign y_abs  = y_sel[SB-1] ? -y_sel : y_sel;
    assign pk_a   = y_abs[SB-1] ? {(SB-1){1'b1}} : y_abs[SB-2:0];
    assign pk_cur = r_ch ? r_pkr : r_pkl;
    assign pk_d   = $signed({1'b0, pk_a}) - $signed({1'b0, pk_cur});
    assign pk_new = (pk_a > pk_cur) ? pk_a
                  : (SB-1)'(PW'($signed({1'b0, pk_cur})) + (r_macc >>> 24));
    assign t_s    = r_uneg ? -$signed({1'b0, r_tmag}) : $signed({1'b0, r_tmag});
    assign q_clamp = (r_dq > U_LIM) ? U_LIM : r_dq;
    assign pl     = inv_l ? neg_sat(r_inl) : r_inl;
    assign pr     = inv_r ? neg_sat(r_inr) : r_inr;

    // mono output mix
    logic signed [SB:0] mono_sum;
    assign mono_sum = $signed({r_yl[SB-1], r_yl}) + $signed({r_yr[SB-1], r_yr});

    // divider trial subtract
    assign d_trial = {r_drem, r_dq[DW-1]};
    assign d_fit   = d_trial >= {1'b0, r_dvs};

    // sequencer
    always_comb begin
        n_state = r_state;  n_pend = r_pend;  n_ch = r_ch;  n_k = r_k;
        n_s_in = r_s_in;  n_s_main = r_s_main;  n_s_out = r_s_out;
        n_s_width = r_s_width;  n_s_ceil = r_s_ceil;
        n_pkl = r_pkl;  n_pkr = r_pkr;
        n_inl = r_inl;  n_inr = r_inr;  n_yl = r_yl;  n_yr = r_yr;
        n_xl = r_xl;  n_xr = r_xr;
        n_umag = r_umag;  n_uneg = r_uneg;  n_u2 = r_u2;
        n_num = r_num;  n_tmag = r_tmag;
        n_ovalid = r_ovalid && i_out_stall;
        n_ol = r_ol;  n_or = r_or;  n_opl = r_opl;  n_opr = r_opr;
        m_go = 1'b0;  m_a = '0;  m_b = '0;
        d_go = 1'b0;  d_dvd = '0;  d_dvs = '0;

        case (r_state)
            sgms_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_inl   = i_left_sample;
                    n_inr   = r_cfg_mode[sgms_pkg::MODE_MONO_IN] ? i_left_sample
                                                                 : i_right_sample;
                    n_k     = 3'd0;
                    n_state = sgms_pkg::S_SMOOTH;
                end
            end
            // five one-pole smoothers, one after another
            sgms_pkg::S_SMOOTH: begin
                if (!r_pend) begin
                    m_go = 1'b1;  m_a = AW'(sm_d);  m_b = coef_e;  n_pend = 1'b1;
                end else if (u_done) begin
                    n_pend = 1'b0;
                    case (r_k)
                        3'd0:    n_s_in    = sm_new[23:0];
                        3'd1:    n_s_main  = sm_new[23:0];
                        3'd2:    n_s_out   = sm_new[23:0];
                        3'd3:    n_s_width = sm_new[16:0];
                        default: n_s_ceil  = sm_new[16:0];
                    endcase
                    if (r_k == 3'd4) n_state = sgms_pkg::S_POL;
                    else             n_k = r_k + 3'd1;
                end
            end
            // polarity, bypass branch
            sgms_pkg::S_POL: begin
                n_yl = pl;  n_yr = pr;
                n_xl = XW'(pl);  n_xr = XW'(pr);
                n_ch = 1'b0;
                n_state = r_cfg_mode[sgms_pkg::MODE_BYPASS] ? sgms_pkg::S_OUTP
                                                            : sgms_pkg::S_TRIM;
            end
            sgms_pkg::S_TRIM, sgms_pkg::S_MAIN, sgms_pkg::S_OUTG: begin
                if (!r_pend) begin
                    m_go = 1'b1;  m_a = AW'(x_sel);  n_pend = 1'b1;
                    m_b = (r_state == sgms_pkg::S_TRIM) ? BW'(r_s_in) :
                          (r_state == sgms_pkg::S_MAIN) ? BW'(r_s_main) : BW'(r_s_out);
                end else if (u_done) begin
                    n_pend = 1'b0;
                    if (r_ch) n_xr = XW'((r_state == sgms_pkg::S_MAIN) ? p_main : p_r20);
                    else      n_xl = XW'((r_state == sgms_pkg::S_MAIN) ? p_main : p_r20);
                    n_ch = !r_ch;
                    if (r_ch) begin
                        n_state = (r_state == sgms_pkg::S_TRIM) ? sgms_pkg::S_MS :
                                  (r_state == sgms_pkg::S_MAIN) ? sgms_pkg::S_OUTG :
                                  sgms_pkg::S_CDIV;
                    end
                end
            end
            // mid/side width: one side product serves both channels
            sgms_pkg::S_MS: begin
                if (!r_pend) begin
                    m_go = 1'b1;  m_a = AW'(r_xl - r_xr);  m_b = BW'(r_s_width);
                    n_pend = 1'b1;
                end else if (u_done) begin
                    n_pend  = 1'b0;
                    n_xl    = XW'((ms_sum + ms_side + K16) >>> 17);
                    n_xr    = XW'((ms_sum - ms_side + K16) >>> 17);
                    n_state = sgms_pkg::S_MAIN;
                end
            end
            // u = x / c, clamped
            sgms_pkg::S_CDIV: begin
                if (!r_pend) begin
                    d_go = 1'b1;  d_dvd = DW'(x_mag) << SHU;  d_dvs = VW'(r_s_ceil);
                    n_pend = 1'b1;
                end else if (u_done) begin
                    n_pend  = 1'b0;
                    n_umag  = q_clamp[23:0];
                    n_uneg  = x_sel[XW-1];
                    n_state = sgms_pkg::S_CU2;
                end
            end
            sgms_pkg::S_CU2: begin
                if (!r_pend) begin
                    m_go = 1'b1;  m_a = AW'($signed({1'b0, r_umag}));  m_b = BW'(r_umag);
                    n_pend = 1'b1;
                end else if (u_done) begin
                    n_pend  = 1'b0;
                    n_u2    = 27'(r_macc >>> 20);
                    n_state = sgms_pkg::S_CNUM;
                end
            end
            sgms_pkg::S_CNUM: begin
                if (!r_pend) begin
                    m_go = 1'b1;
                    m_a  = AW'($signed({1'b0, 28'(sgms_pkg::TANH_27) + 28'(r_u2)}));
                    m_b  = BW'(r_umag);
                    n_pend = 1'b1;
                end else if (u_done) begin
                    n_pend  = 1'b0;
                    n_num   = DW'(r_macc);
                    n_state = sgms_pkg::S_CTDIV;
                end
            end
            // t = num / (27 + 9 u^2)
            sgms_pkg::S_CTDIV: begin
                if (!r_pend) begin
                    d_go  = 1'b1;  d_dvd = r_num;
                    d_dvs = VW'(sgms_pkg::TANH_27) + VW'({r_u2, 3'b000}) + VW'(r_u2);
                    n_pend = 1'b1;
                end else if (u_done) begin
                    n_pend  = 1'b0;
                    n_tmag  = r_dq[23:0];
                    n_state = sgms_pkg::S_CY;
                end
            end
            // y = t * c, saturated
            sgms_pkg::S_CY: begin
                if (!r_pend) begin
                    m_go = 1'b1;  m_a = AW'(t_s);  m_b = BW'(r_s_ceil);  n_pend = 1'b1;
                end else if (u_done) begin
                    n_pend = 1'b0;
                    if (r_ch) n_yr = SB'(p_y);
                    else      n_yl = SB'(p_y);
                    n_state = sgms_pkg::S_PEAK;
                end
            end
            // peak meter: instant attack, slow release
            sgms_pkg::S_PEAK: begin
                if (!r_pend) begin
                    m_go = 1'b1;  m_a = AW'(pk_d);
                    m_b = BW'(sgms_pkg::PEAK_RELEASE);  n_pend = 1'b1;
                end else if (u_done) begin
                    n_pend = 1'b0;
                    if (r_ch) n_pkr = pk_new;
                    else      n_pkl = pk_new;
                    n_ch    = !r_ch;
                    n_state = r_ch ? sgms_pkg::S_OUTP : sgms_pkg::S_CDIV;
                end
            end
            // hand the item to the output register once it is free
            sgms_pkg::S_OUTP: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    if (r_cfg_mode[sgms_pkg::MODE_MONO_OUT]) begin
                        n_ol = SB'(mono_sum >>> 1);
                        n_or = '0;
                    end else begin
                        n_ol = r_yl;
                        n_or = r_yr;
                    end
                    n_opl   = r_pkl;
                    n_opr   = r_pkr;
                    n_state = sgms_pkg::S_IDLE;
                end
            end
            default: n_state = sgms_pkg::S_IDLE;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_in    <= 24'(sgms_pkg::RST_IN_TRIM);
            r_cfg_main  <= 24'(sgms_pkg::RST_MAIN);
            r_cfg_out   <= 24'(sgms_pkg::RST_OUT_TRIM);
            r_cfg_width <= 17'(sgms_pkg::RST_WIDTH);
            r_cfg_ceil  <= 17'(sgms_pkg::RST_CEILING);
            r_cfg_coef  <= 25'(sgms_pkg::RST_COEF);
            r_cfg_mode  <= 6'(sgms_pkg::RST_MODE);
            r_s_in      <= 24'(sgms_pkg::GAIN_ONE);
            r_s_main    <= 24'(sgms_pkg::GAIN_ONE);
            r_s_out     <= 24'(sgms_pkg::GAIN_ONE);
            r_s_width   <= '0;
            r_s_ceil    <= 17'(sgms_pkg::CEIL_RESET);
            r_pkl       <= '0;
            r_pkr       <= '0;
            r_state     <= sgms_pkg::S_IDLE;
            r_pend      <= 1'b0;
            r_ch        <= 1'b0;
            r_k         <= '0;
            r_ovalid    <= 1'b0;
            r_mplr      <= '0;
            r_dcnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sgms_pkg::REG_IN_TRIM:  r_cfg_in    <= i_cfg_data[23:0];
                    sgms_pkg::REG_MAIN:     r_cfg_main  <= i_cfg_data[23:0];
                    sgms_pkg::REG_OUT_TRIM: r_cfg_out   <= i_cfg_data[23:0];
                    sgms_pkg::REG_WIDTH:    r_cfg_width <= i_cfg_data[16:0];
                    sgms_pkg::REG_CEILING:  r_cfg_ceil  <= i_cfg_data[16:0];
                    sgms_pkg::REG_COEF:     r_cfg_coef  <= i_cfg_data[24:0];
                    sgms_pkg::REG_MODE:     r_cfg_mode  <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            r_s_in    <= n_s_in;
            r_s_main  <= n_s_main;
            r_s_out   <= n_s_out;
            r_s_width <= n_s_width;
            r_s_ceil  <= n_s_ceil;
            r_pkl     <= n_pkl;
            r_pkr     <= n_pkr;
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_ch      <= n_ch;
            r_k       <= n_k;
            r_ovalid  <= n_ovalid;

            // shift-add multiplier, exits when no multiplier bits remain
            if (m_go) begin
                r_macc <= '0;
                r_mcd  <= PW'(m_a);
                r_mplr <= m_b;
            end else if (r_mplr != '0) begin
                if (r_mplr[0]) r_macc <= r_macc + r_mcd;
                r_mcd  <= r_mcd <<< 1;
                r_mplr <= r_mplr >> 1;
            end

            // restoring divider, one quotient bit per cycle
            if (d_go) begin
                r_dq   <= d_dvd;
                r_dvs  <= d_dvs;
                r_drem <= '0;
                r_dcnt <= DCW'(DW);
            end else if (r_dcnt != '0) begin
                r_drem <= d_fit ? VW'(d_trial - {1'b0, r_dvs}) : d_trial[VW-1:0];
                r_dq   <= {r_dq[DW-2:0], d_fit};
                r_dcnt <= r_dcnt - DCW'(1);
            end
        end
    end

    // frame and output payload
    always_ff @(posedge i_clk) begin
        r_inl  <= n_inl;
        r_inr  <= n_inr;
        r_yl   <= n_yl;
        r_yr   <= n_yr;
        r_xl   <= n_xl;
        r_xr   <= n_xr;
        r_umag <= n_umag;
        r_uneg <= n_uneg;
        r_u2   <= n_u2;
        r_num  <= n_num;
        r_tmag <= n_tmag;
        r_ol   <= n_ol;
        r_or   <= n_or;
        r_opl  <= n_opl;
        r_opr  <= n_opr;
    end

    assign o_in_stall   = (r_state != sgms_pkg::S_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_left_out   = r_ol;
    assign o_right_out  = r_or;
    assign o_peak_left  = r_opl;
    assign o_peak_right = r_opr;

    // checks
    `SGMS_ASSERT_NEXT(a_accept_starts, (i_in_valid && !o_in_stall), (r_state == sgms_pkg::S_SMOOTH), "accepted item did not start the smoothers")
    `SGMS_ASSERT_NOW(a_units_exclusive, (r_mplr != '0), (r_pend && (r_dcnt == '0)), "multiplier running without a pending operation or alongside the divider")
    `SGMS_ASSERT_NEXT(a_result_loaded, ((r_state == sgms_pkg::S_OUTP) && (!r_ovalid || !i_out_stall)), (o_out_valid && (r_state == sgms_pkg::S_IDLE)), "finished item not loaded into the output register")

endmodule
